[sv/bounded_sequence_list_engine_macros.svh]
// ----------------------------------------------------------------------------
// bounded sequence list engine assertion macros
// shared property shapes for the port checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENCE_LIST_ENGINE_MACROS_SVH
`define BOUNDED_SEQUENCE_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define BSLE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsle port check failed");

// next-cycle implication
`define BSLE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsle port check failed");

`endif

[sv/bsle_pkg.sv]
// ----------------------------------------------------------------------------
// bsle_pkg
// widths, command and status codes, micro-ops and controller/datapath structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsle_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int KEY_W = 32;
    localparam int CMD_W = 4;
    localparam int POS_W = 6;
    localparam int ST_W  = 3;
    localparam int OP_W  = 5;

    // command codes of the input word
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_F  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_B  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_POP_F   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_POP_B   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 4'd7;
    localparam logic [CMD_W-1:0] CMD_READ    = 4'd8;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [ST_W-1:0] ST_NOKEY = 3'd3;
    localparam logic [ST_W-1:0] ST_RANGE = 3'd4;

    // datapath micro-ops
    localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 5'd2;
    localparam logic [OP_W-1:0] OP_PUSH_F    = 5'd3;
    localparam logic [OP_W-1:0] OP_PUSH_B    = 5'd4;
    localparam logic [OP_W-1:0] OP_RD_FRONT  = 5'd5;
    localparam logic [OP_W-1:0] OP_RD_BACK   = 5'd6;
    localparam logic [OP_W-1:0] OP_RD_POS    = 5'd7;
    localparam logic [OP_W-1:0] OP_POP_F     = 5'd8;
    localparam logic [OP_W-1:0] OP_POP_B     = 5'd9;
    localparam logic [OP_W-1:0] OP_TAKE      = 5'd10;
    localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd11;
    localparam logic [OP_W-1:0] OP_SCAN      = 5'd12;
    localparam logic [OP_W-1:0] OP_SH_INIT   = 5'd13;
    localparam logic [OP_W-1:0] OP_SHIFT     = 5'd14;
    localparam logic [OP_W-1:0] OP_INS_KEY   = 5'd15;
    localparam logic [OP_W-1:0] OP_DEL_FIN   = 5'd16;
    localparam logic [OP_W-1:0] OP_REV_START = 5'd17;
    localparam logic [OP_W-1:0] OP_REV_WA    = 5'd18;
    localparam logic [OP_W-1:0] OP_REV_WB    = 5'd19;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            st_we;
        logic [ST_W-1:0] st;
        logic            emit;
    } dp_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             pos_oob;
        logic             cnt_le1;
        logic             scan_hit;
        logic             scan_miss;
        logic             shift_done;
        logic             rev_more;
    } dp_stat_t;

endpackage

`default_nettype wire

[sv/bsle_ctrl.sv]
// ----------------------------------------------------------------------------
// bsle_ctrl
// command sequencer: accepts a word, steps the datapath, hands off the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsle_ctrl
    import bsle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_ctrl_t ctrl,
    input  dp_stat_t stat
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_POP      = 4'd2;
    localparam logic [3:0] S_TAKE     = 4'd3;
    localparam logic [3:0] S_SCAN     = 4'd4;
    localparam logic [3:0] S_SH_INIT  = 4'd5;
    localparam logic [3:0] S_SHIFT    = 4'd6;
    localparam logic [3:0] S_REV_WA   = 4'd7;
    localparam logic [3:0] S_REV_WB   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '{op: OP_NOP, st_we: 1'b0, st: ST_OK, emit: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.op    = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                unique case (stat.cmd) inside
                    CMD_CLEAR:
                        ctrl.op = OP_CLEAR;
                    CMD_PUSH_F:
                    begin
                        if (stat.full)
                        begin
                            ctrl.st_we = 1'b1;
                            ctrl.st    = ST_FULL;
                        end
                        else
                            ctrl.op = OP_PUSH_F;
                    end
                    CMD_PUSH_B:
                    begin
                        if (stat.full)
                        begin
                            ctrl.st_we = 1'b1;
                            ctrl.st    = ST_FULL;
                        end
                        else
                            ctrl.op = OP_PUSH_B;
                    end
                    CMD_POP_F, CMD_POP_B:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.st_we = 1'b1;
                            ctrl.st    = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.op    = (stat.cmd == CMD_POP_F) ? OP_RD_FRONT : OP_RD_BACK;
                            state_next = S_POP;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            ctrl.st_we = 1'b1;
                            ctrl.st    = ST_FULL;
                        end
                        else
                        begin
                            ctrl.op    = OP_SCAN_INIT;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.st_we = 1'b1;
                            ctrl.st    = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.op    = OP_SCAN_INIT;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_REVERSE:
                    begin
                        if (!stat.cnt_le1)
                        begin
                            ctrl.op    = OP_REV_START;
                            state_next = S_REV_WA;
                        end
                    end
                    CMD_READ:
                    begin
                        if (stat.pos_oob)
                        begin
                            ctrl.st_we = 1'b1;
                            ctrl.st    = ST_RANGE;
                        end
                        else
                        begin
                            ctrl.op    = OP_RD_POS;
                            state_next = S_TAKE;
                        end
                    end
                    default:
                    begin
                        // unused codes leave the list alone
                    end
                endcase
            end
            S_POP:
            begin
                ctrl.op    = (stat.cmd == CMD_POP_F) ? OP_POP_F : OP_POP_B;
                state_next = S_DONE;
            end
            S_TAKE:
            begin
                ctrl.op    = OP_TAKE;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                ctrl.op = OP_SCAN;
                if (stat.scan_hit)
                    state_next = S_SH_INIT;
                else if (stat.scan_miss)
                begin
                    if (stat.cmd == CMD_DELETE)
                    begin
                        ctrl.st_we = 1'b1;
                        ctrl.st    = ST_NOKEY;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_SH_INIT;
                end
            end
            S_SH_INIT:
            begin
                ctrl.op    = OP_SH_INIT;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    ctrl.op    = (stat.cmd == CMD_INSERT) ? OP_INS_KEY : OP_DEL_FIN;
                    state_next = S_DONE;
                end
                else
                    ctrl.op = OP_SHIFT;
            end
            S_REV_WA:
            begin
                ctrl.op    = OP_REV_WA;
                state_next = S_REV_WB;
            end
            S_REV_WB:
            begin
                ctrl.op    = OP_REV_WB;
                state_next = stat.rev_more ? S_REV_WA : S_DONE;
            end
            S_DONE:
            begin
                // output register free or draining this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/bsle_datapath.sv]
// ----------------------------------------------------------------------------
// bsle_datapath
// key ring memory, front index, count, walk pointers and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsle_datapath
    import bsle_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic        [CMD_W-1:0]            cmd,
    input  logic signed [KEY_W-1:0]            key_value,
    input  logic        [POS_W-1:0]            position,
    input  dp_ctrl_t                           ctrl,
    output dp_stat_t                           stat,
    output logic        [ST_W-1:0]             status,
    output logic        [$clog2(CAPACITY+1)-1:0] item_count,
    output logic signed [KEY_W-1:0]            data_out
);

    localparam int SW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = CW + POS_W;
    localparam logic [CW:0] CAP_X = (CW+1)'(CAPACITY);

    // position from the front to ring slot
    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] f, input logic [CW-1:0] p);
        logic [CW:0] s;
        s = (CW+1)'(f) + (CW+1)'(p);
        if (s >= CAP_X)
            s = s - CAP_X;
        return s[SW-1:0];
    endfunction

    logic signed [KEY_W-1:0] mem [CAPACITY];
    logic signed [KEY_W-1:0] rd_a_reg;
    logic signed [KEY_W-1:0] rd_b_reg;

    logic        [CMD_W-1:0] cmd_reg,      cmd_next;
    logic signed [KEY_W-1:0] key_reg,      key_next;
    logic        [POS_W-1:0] pos_reg,      pos_next;
    logic        [SW-1:0]    front_reg,    front_next;
    logic        [CW-1:0]    count_reg,    count_next;
    logic        [CW-1:0]    rp_reg,       rp_next;
    logic        [CW-1:0]    hi_reg,       hi_next;
    logic        [CW-1:0]    n_reg,        n_next;
    logic        [CW-1:0]    ppos_reg,     ppos_next;
    logic                    pv_reg,       pv_next;
    logic        [CW-1:0]    hit_pos_reg,  hit_pos_next;
    logic        [ST_W-1:0]  res_st_reg,   res_st_next;
    logic signed [KEY_W-1:0] res_data_reg, res_data_next;
    logic        [ST_W-1:0]  out_st_reg,   out_st_next;
    logic        [CW-1:0]    out_cnt_reg,  out_cnt_next;
    logic signed [KEY_W-1:0] out_data_reg, out_data_next;

    logic                    we;
    logic        [SW-1:0]    waddr;
    logic signed [KEY_W-1:0] wdata;
    logic                    re_a;
    logic        [SW-1:0]    raddr_a;
    logic                    re_b;
    logic        [SW-1:0]    raddr_b;

    logic        [CW-1:0]    cnt_m1;
    logic        [SW-1:0]    front_dec;
    logic        [SW-1:0]    front_inc;
    logic                    hit_cond;
    logic                    is_insert;

    assign cnt_m1    = count_reg - CW'(1);
    assign front_dec = (front_reg == '0) ? SW'(CAPACITY - 1) : front_reg - SW'(1);
    assign front_inc = (front_reg == SW'(CAPACITY - 1)) ? '0 : front_reg + SW'(1);
    assign is_insert = (cmd_reg == CMD_INSERT);
    // insert stops at the first key not less than the new one, delete at an equal key
    assign hit_cond  = is_insert ? !(rd_a_reg < key_reg) : (rd_a_reg == key_reg);

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.full       = (count_reg == CW'(CAPACITY));
        stat.empty      = (count_reg == '0);
        stat.pos_oob    = (CMP_W'(pos_reg) >= CMP_W'(count_reg));
        stat.cnt_le1    = (count_reg <= CW'(1));
        stat.scan_hit   = pv_reg && hit_cond;
        stat.scan_miss  = (count_reg == '0) || (pv_reg && !hit_cond && (ppos_reg == cnt_m1));
        stat.shift_done = (n_reg == '0) && !pv_reg;
        stat.rev_more   = ((rp_reg + CW'(1)) < (hi_reg - CW'(1)));
    end

    // memory port selection
    always_comb
    begin
        we      = 1'b0;
        waddr   = '0;
        wdata   = key_reg;
        re_a    = 1'b0;
        raddr_a = '0;
        re_b    = 1'b0;
        raddr_b = '0;
        unique case (ctrl.op)
            OP_PUSH_F:
            begin
                we    = 1'b1;
                waddr = front_dec;
            end
            OP_PUSH_B:
            begin
                we    = 1'b1;
                waddr = slot_of(front_reg, count_reg);
            end
            OP_RD_FRONT:
            begin
                re_a    = 1'b1;
                raddr_a = front_reg;
            end
            OP_RD_BACK:
            begin
                re_a    = 1'b1;
                raddr_a = slot_of(front_reg, cnt_m1);
            end
            OP_RD_POS:
            begin
                re_a    = 1'b1;
                raddr_a = slot_of(front_reg, CW'(pos_reg));
            end
            OP_SCAN:
            begin
                if (rp_reg < count_reg)
                begin
                    re_a    = 1'b1;
                    raddr_a = slot_of(front_reg, rp_reg);
                end
            end
            OP_SHIFT:
            begin
                if (n_reg != '0)
                begin
                    re_a    = 1'b1;
                    raddr_a = slot_of(front_reg, rp_reg);
                end
                // write the word read last cycle one place up or down
                if (pv_reg)
                begin
                    we    = 1'b1;
                    waddr = is_insert ? slot_of(front_reg, ppos_reg + CW'(1))
                                      : slot_of(front_reg, ppos_reg - CW'(1));
                    wdata = rd_a_reg;
                end
            end
            OP_INS_KEY:
            begin
                we    = 1'b1;
                waddr = slot_of(front_reg, hit_pos_reg);
            end
            OP_REV_START:
            begin
                re_a    = 1'b1;
                raddr_a = front_reg;
                re_b    = 1'b1;
                raddr_b = slot_of(front_reg, cnt_m1);
            end
            OP_REV_WA:
            begin
                we    = 1'b1;
                waddr = slot_of(front_reg, rp_reg);
                wdata = rd_b_reg;
            end
            OP_REV_WB:
            begin
                we    = 1'b1;
                waddr = slot_of(front_reg, hi_reg);
                wdata = rd_a_reg;
                if (stat.rev_more)
                begin
                    re_a    = 1'b1;
                    raddr_a = slot_of(front_reg, rp_reg + CW'(1));
                    re_b    = 1'b1;
                    raddr_b = slot_of(front_reg, hi_reg - CW'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        rp_next       = rp_reg;
        hi_next       = hi_reg;
        n_next        = n_reg;
        ppos_next     = ppos_reg;
        pv_next       = pv_reg;
        hit_pos_next  = hit_pos_reg;
        res_st_next   = res_st_reg;
        res_data_next = res_data_reg;
        out_st_next   = out_st_reg;
        out_cnt_next  = out_cnt_reg;
        out_data_next = out_data_reg;

        if (ctrl.st_we)
            res_st_next = ctrl.st;

        unique case (ctrl.op)
            OP_LOAD:
            begin
                cmd_next      = cmd;
                key_next      = key_value;
                pos_next      = position;
                res_st_next   = ST_OK;
                res_data_next = '0;
            end
            OP_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            OP_PUSH_F:
            begin
                front_next = front_dec;
                count_next = count_reg + CW'(1);
            end
            OP_PUSH_B:
                count_next = count_reg + CW'(1);
            OP_POP_F:
            begin
                res_data_next = rd_a_reg;
                front_next    = front_inc;
                count_next    = cnt_m1;
            end
            OP_POP_B:
            begin
                res_data_next = rd_a_reg;
                count_next    = cnt_m1;
            end
            OP_TAKE:
                res_data_next = rd_a_reg;
            OP_SCAN_INIT:
            begin
                rp_next = '0;
                pv_next = 1'b0;
            end
            OP_SCAN:
            begin
                pv_next   = (rp_reg < count_reg);
                ppos_next = rp_reg;
                if (rp_reg < count_reg)
                    rp_next = rp_reg + CW'(1);
                if (stat.scan_hit)
                begin
                    hit_pos_next = ppos_reg;
                    if (!is_insert)
                        res_data_next = rd_a_reg;
                end
                else if (stat.scan_miss)
                    hit_pos_next = count_reg;
            end
            OP_SH_INIT:
            begin
                pv_next = 1'b0;
                if (is_insert)
                begin
                    rp_next = cnt_m1;
                    n_next  = count_reg - hit_pos_reg;
                end
                else
                begin
                    rp_next = hit_pos_reg + CW'(1);
                    n_next  = cnt_m1 - hit_pos_reg;
                end
            end
            OP_SHIFT:
            begin
                if (n_reg != '0)
                begin
                    pv_next   = 1'b1;
                    ppos_next = rp_reg;
                    n_next    = n_reg - CW'(1);
                    rp_next   = is_insert ? rp_reg - CW'(1) : rp_reg + CW'(1);
                end
                else
                    pv_next = 1'b0;
            end
            OP_INS_KEY:
                count_next = count_reg + CW'(1);
            OP_DEL_FIN:
                count_next = cnt_m1;
            OP_REV_START:
            begin
                rp_next = '0;
                hi_next = cnt_m1;
            end
            OP_REV_WB:
            begin
                rp_next = rp_reg + CW'(1);
                hi_next = hi_reg - CW'(1);
            end
            default:
            begin
            end
        endcase

        if (ctrl.emit)
        begin
            out_st_next   = res_st_reg;
            out_cnt_next  = count_reg;
            out_data_next = res_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re_a)
            rd_a_reg <= mem[raddr_a];
        if (re_b)
            rd_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        rp_reg       <= rp_next;
        hi_reg       <= hi_next;
        n_reg        <= n_next;
        ppos_reg     <= ppos_next;
        hit_pos_reg  <= hit_pos_next;
        res_st_reg   <= res_st_next;
        res_data_reg <= res_data_next;
        out_st_reg   <= out_st_next;
        out_cnt_reg  <= out_cnt_next;
        out_data_reg <= out_data_next;
    end

    assign status     = out_st_reg;
    assign item_count = out_cnt_reg;
    assign data_out   = out_data_reg;

endmodule

`default_nettype wire

[sv/bounded_sequence_list_engine.sv]
// ----------------------------------------------------------------------------
// bounded_sequence_list_engine
// ordered list of up to CAPACITY signed keys kept as a ring in one memory
// ----------------------------------------------------------------------------
// input channel: cmd, key_value, position with in_valid / in_stall; a word is
// taken when in_valid is high and in_stall is low. in_stall stays high from
// the accepting edge until the result word has entered the output register.
// output channel: status, item_count, data_out with out_valid / out_stall;
// exactly one result word per command, held steady while out_stall is high.
// clear, push and rejected commands finish at dispatch, pops and read add a
// memory read step, and reverse, key delete and ordered insert walk the list.
// the walks are set by the single write port of the key memory: a walk moves
// one key per cycle and a reverse writes the two keys of each pair in turn.
// a new command is taken as soon as the previous result is in the output
// register, even while that result is still stalled; the next result waits
// in the sequencer until the output register drains.
// reset clears the count and front index, so the list starts empty; the key
// memory needs no clearing pass since only held positions are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_sequence_list_engine
    import bsle_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic        [CMD_W-1:0]              cmd,
    input  logic signed [KEY_W-1:0]              key_value,
    input  logic        [POS_W-1:0]              position,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic        [ST_W-1:0]               status,
    output logic        [$clog2(CAPACITY+1)-1:0] item_count,
    output logic signed [KEY_W-1:0]              data_out
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    bsle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    bsle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key_value  (key_value),
        .position   (position),
        .ctrl       (ctrl),
        .stat       (stat),
        .status     (status),
        .item_count (item_count),
        .data_out   (data_out)
    );

endmodule

`default_nettype wire

[sv/bsle_checker.sv]
// ----------------------------------------------------------------------------
// bsle_checker
// port-level checks on result words, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_sequence_list_engine_macros.svh"

module bsle_checker
    import bsle_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic        [ST_W-1:0]               status,
    input logic        [$clog2(CAPACITY+1)-1:0] item_count,
    input logic signed [KEY_W-1:0]              data_out
);

    // stalled result word holds
    `BSLE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(item_count) && $stable(data_out))

    // count never runs past capacity
    `BSLE_ASSERT_IMP(a_count_bound, out_valid, item_count <= CAPACITY)

    // full is reported only on a full list
    `BSLE_ASSERT_IMP(a_full_count, out_valid && (status == ST_FULL), item_count == CAPACITY)

    // empty is reported only on an empty list
    `BSLE_ASSERT_IMP(a_empty_count, out_valid && (status == ST_EMPTY), item_count == 0)

    // failed commands return a zero key
    `BSLE_ASSERT_IMP(a_fail_zero, out_valid && (status != ST_OK), data_out == 0)

endmodule

bind bounded_sequence_list_engine bsle_checker #(
    .CAPACITY (CAPACITY)
) u_bsle_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .item_count (item_count),
    .data_out   (data_out)
);

`default_nettype wire
